[src/art_pkg.sv]
// art_pkg: shared types and constants for the auto relock timer
// item structs, timer state struct, register indexes and reset values
// no dependencies
package art_pkg;

	localparam int unsigned TimeW = 32;
	localparam int unsigned CfgIdxW = 2;

	// register indexes on the configuration port
	localparam logic [CfgIdxW-1:0] CFG_DOOR_CLOSE_DELAY = 2'd0;
	localparam logic [CfgIdxW-1:0] CFG_LOCK_OPEN_DELAY  = 2'd1;
	localparam logic [CfgIdxW-1:0] CFG_WARN_LEAD        = 2'd2;

	// command codes
	localparam logic CMD_POLL = 1'b0;
	localparam logic CMD_HOLD = 1'b1;

	localparam logic [TimeW-1:0] DOOR_CLOSE_DELAY_RST = 32'd10000;
	localparam logic [TimeW-1:0] LOCK_OPEN_DELAY_RST  = 32'd30000;
	localparam logic [TimeW-1:0] WARN_LEAD_RST        = 32'd3000;

	typedef struct packed {
		logic             cmd;
		logic             door_is_closed;
		logic             lock_is_open;
		logic [TimeW-1:0] now_ms;
		logic [TimeW-1:0] manual_delay_ms;
	} art_req_t;

	typedef struct packed {
		logic             warn_pulse;
		logic             close_pulse;
		logic [TimeW-1:0] remaining_ms;
		logic             hold_active;
	} art_rsp_t;

	typedef struct packed {
		logic [TimeW-1:0] door_close_delay_ms;
		logic [TimeW-1:0] lock_open_delay_ms;
		logic [TimeW-1:0] warn_lead_ms;
	} art_cfg_t;

	typedef struct packed {
		logic [TimeW-1:0] deadline;
		logic             warned;
		logic             hold;
		logic             prev_door_closed;
		logic             prev_lock_open;
		logic             started;
	} art_state_t;

endpackage

[src/art_step.sv]
// art_step: combinational update of the relock timer for one item
// takes the current state, the item and the registers; gives next state and result
// depends on art_pkg
module art_step import art_pkg::*; (
	input  art_req_t   req,
	input  art_cfg_t   cfg,
	input  art_state_t cur,
	output art_state_t nxt,
	output art_rsp_t   rsp
);

	logic             warn;
	logic             close;
	logic [TimeW-1:0] warn_at;

	always_comb begin
		nxt     = cur;
		warn    = 1'b0;
		close   = 1'b0;
		warn_at = '0;
		if (req.cmd == CMD_HOLD) begin
			nxt.deadline = req.now_ms + req.manual_delay_ms;
			nxt.warned   = 1'b0;
			nxt.hold     = 1'b1;
		end else if (!cur.started) begin
			nxt.prev_door_closed = req.door_is_closed;
			nxt.prev_lock_open   = req.lock_is_open;
			nxt.started          = 1'b1;
		end else begin
			// door opened: cancel
			if (!req.door_is_closed && cur.prev_door_closed && !cur.hold) begin
				nxt.deadline = '0;
				nxt.warned   = 1'b0;
				nxt.hold     = 1'b0;
			end
			// door closed: schedule
			if (req.door_is_closed && !cur.prev_door_closed && !cur.hold) begin
				nxt.deadline = req.now_ms + cfg.door_close_delay_ms;
				nxt.warned   = 1'b0;
			end
			// lock opened with door closed: longer schedule, wins over the above
			if (req.lock_is_open && !cur.prev_lock_open && req.door_is_closed && !cur.hold) begin
				nxt.deadline = req.now_ms + cfg.lock_open_delay_ms;
				nxt.warned   = 1'b0;
			end
			nxt.prev_door_closed = req.door_is_closed;
			nxt.prev_lock_open   = req.lock_is_open;

			warn_at = nxt.deadline - cfg.warn_lead_ms;
			if (nxt.deadline != '0) begin
				if (!req.lock_is_open) begin
					// lock already closed: cancel silently
					nxt.deadline = '0;
					nxt.warned   = 1'b0;
					nxt.hold     = 1'b0;
				end else begin
					if (!nxt.warned && req.now_ms >= warn_at) begin
						warn       = 1'b1;
						nxt.warned = 1'b1;
					end
					if (req.now_ms >= nxt.deadline) begin
						close        = 1'b1;
						nxt.deadline = '0;
						nxt.warned   = 1'b0;
						nxt.hold     = 1'b0;
					end
				end
			end
		end

		rsp.warn_pulse   = warn;
		rsp.close_pulse  = close;
		rsp.hold_active  = nxt.hold;
		if (nxt.deadline == '0 || req.now_ms >= nxt.deadline) begin
			rsp.remaining_ms = '0;
		end else begin
			rsp.remaining_ms = nxt.deadline - req.now_ms;
		end
	end

endmodule

[src/auto_relock_timer.sv]
// auto_relock_timer: top level of the automatic relock timer
// input register, timer state, configuration registers and result register
// depends on art_pkg and art_step
//
//  channel   | valid      | stall      | payload
//  ----------+------------+------------+---------------------------
//  request   | req_valid  | req_stall  | req   (art_req_t)
//  result    | rsp_valid  | rsp_stall  | rsp   (art_rsp_t)
//  config    | cfg_we     | -          | cfg_idx, cfg_wdata
//
// one item a cycle while the result is not stalled; an item passes from the input register
// into the result register, where its result is shown and can be taken at the next edge
// the timer state is updated as the item moves into the result register, so
// each item sees the state left by the one before it
// reset clears the timer state, the valid flags and loads the register defaults
// a stalled result holds; the input side stalls only while both registers are
// full and the result is stalled
module auto_relock_timer import art_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  art_req_t           req,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output art_rsp_t           rsp,
	input  logic               cfg_we,
	input  logic [CfgIdxW-1:0] cfg_idx,
	input  logic [TimeW-1:0]   cfg_wdata
);

	// input stage
	logic       valid_s1;
	art_req_t   req_s1;

	// timer state and registers
	art_state_t state_q;
	art_state_t state_nxt;
	art_cfg_t   cfg_q;

	// result register
	logic       rsp_valid_q;
	art_rsp_t   rsp_q;
	art_rsp_t   rsp_nxt;

	logic       advance;
	logic       load_out;

	// the result register can take a new item when empty or being drained
	assign advance   = !rsp_valid_q || !rsp_stall;
	assign load_out  = valid_s1 && advance;
	assign req_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!req_stall) begin
			valid_s1 <= req_valid;
		end
	end

	// payload of the input stage, no reset needed
	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			req_s1 <= req;
		end
	end

	// all the decision logic for one item
	art_step u_step (
		.req (req_s1),
		.cfg (cfg_q),
		.cur (state_q),
		.nxt (state_nxt),
		.rsp (rsp_nxt)
	);

	// timer state moves on only when its item is committed to the output
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (load_out) begin
			state_q <= state_nxt;
		end
	end

	// configuration writes, an index beyond the list is dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.door_close_delay_ms <= DOOR_CLOSE_DELAY_RST;
			cfg_q.lock_open_delay_ms  <= LOCK_OPEN_DELAY_RST;
			cfg_q.warn_lead_ms        <= WARN_LEAD_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_DOOR_CLOSE_DELAY: cfg_q.door_close_delay_ms <= cfg_wdata;
				CFG_LOCK_OPEN_DELAY:  cfg_q.lock_open_delay_ms  <= cfg_wdata;
				CFG_WARN_LEAD:        cfg_q.warn_lead_ms        <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			rsp_q <= rsp_nxt;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// a close always leaves nothing scheduled
	a_close_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(load_out && rsp_nxt.close_pulse) |=> (state_q.deadline == '0))
		else $error("deadline left pending after close");

	// a close item reports no time left
	a_close_zero_left: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.close_pulse) |-> (rsp.remaining_ms == '0))
		else $error("time left reported on a close");

	// reported hold matches the state the item left behind
	a_hold_matches: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> (rsp_q.hold_active == state_q.hold))
		else $error("hold flag in result disagrees with state");

	// input is only held off by a full input stage behind a full, stalled result register
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> (valid_s1 && rsp_valid_q && rsp_stall))
		else $error("input stalled without a blocked output");

endmodule
